[rtl/core/hmms_pkg.sv]
`default_nettype none

package hmms_pkg;

  // input action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_MOVE    = 3'd1;
  localparam logic [2:0] ACT_BUTTONS = 3'd2;
  localparam logic [2:0] ACT_WHEEL   = 3'd3;
  localparam logic [2:0] ACT_PAN     = 3'd4;
  localparam logic [2:0] ACT_RAW     = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_STEPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_LIMIT = 2'd1;

  localparam logic [7:0] GLIDE_STEPS_RESET  = 8'd24;
  localparam logic [6:0] DIRECT_LIMIT_RESET = 7'd63;

  // width of the motion words and of the step divider
  localparam int DIV_W = 16;

  typedef struct packed {
    logic        [2:0]  action;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic        [7:0]  button_mask;
    logic signed [7:0]  wheel_amount;
    logic signed [7:0]  pan_amount;
  } in_item_t;

  typedef struct packed {
    logic        [7:0] report_buttons;
    logic signed [7:0] report_dx;
    logic signed [7:0] report_dy;
    logic signed [7:0] report_wheel;
    logic signed [7:0] report_pan;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_REPORT,
    OP_GOAL,
    OP_BUTTONS,
    OP_WHEEL,
    OP_PAN
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [7:0]  val;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_APPLY
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/hmms_front.sv]
`default_nettype none

module hmms_front import hmms_pkg::*; (
  input  logic       in_valid,
  input  in_item_t   in_data,
  input  logic [6:0] direct_limit,
  output logic       push,
  output cmd_t       cmd
);

  logic [15:0] mag_x;
  logic [15:0] mag_y;
  logic        is_small;
  logic        keep;

  assign mag_x = in_data.move_x[15] ? (~in_data.move_x + 16'd1) : in_data.move_x;
  assign mag_y = in_data.move_y[15] ? (~in_data.move_y + 16'd1) : in_data.move_y;
  assign is_small = (mag_x <= {9'd0, direct_limit}) && (mag_y <= {9'd0, direct_limit});

  always_comb begin
    keep    = 1'b0;
    cmd.op  = OP_TICK;
    cmd.x   = in_data.move_x;
    cmd.y   = in_data.move_y;
    cmd.val = in_data.button_mask;
    case (in_data.action)
      ACT_TICK: begin
        keep = 1'b1;
      end
      ACT_MOVE: begin
        // zero moves are dropped here
        keep   = (in_data.move_x != 16'sd0) || (in_data.move_y != 16'sd0);
        cmd.op = is_small ? OP_REPORT : OP_GOAL;
      end
      ACT_BUTTONS: begin
        keep   = 1'b1;
        cmd.op = OP_BUTTONS;
      end
      ACT_WHEEL: begin
        keep    = 1'b1;
        cmd.op  = OP_WHEEL;
        cmd.val = in_data.wheel_amount;
      end
      ACT_PAN: begin
        keep    = 1'b1;
        cmd.op  = OP_PAN;
        cmd.val = in_data.pan_amount;
      end
      ACT_RAW: begin
        // raw delta only looks at the low byte of each component
        keep   = (in_data.move_x[7:0] != 8'd0) || (in_data.move_y[7:0] != 8'd0);
        cmd.op = OP_REPORT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && keep;

endmodule

`default_nettype wire

[rtl/core/hmms_queue.sv]
`default_nettype none

module hmms_queue import hmms_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/hmms_div.sv]
`default_nettype none

module hmms_div import hmms_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic        [7:0]       divisor,
  output logic                    done,
  output logic signed [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] num_r;
  logic [7:0]       part_r;
  logic [7:0]       den_r;
  logic             neg_r;
  logic [8:0]       trial;
  logic [8:0]       trial_sub;
  logic             fits;
  logic [DIV_W-1:0] mag_in;

  // restoring division, one quotient bit a cycle, quotient shifts into num_r
  assign trial     = {part_r, num_r[DIV_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = (trial >= {1'b0, den_r});
  assign mag_in    = dividend[DIV_W-1] ? (~dividend + DIV_W'(1)) : dividend;

  assign done     = done_r;
  assign quotient = neg_r ? $signed(~num_r + DIV_W'(1)) : $signed(num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= mag_in;
      neg_r  <= dividend[DIV_W-1];
      den_r  <= divisor;
      part_r <= 8'd0;
    end else if (busy_r) begin
      num_r  <= {num_r[DIV_W-2:0], fits};
      part_r <= fits ? trial_sub[7:0] : trial[7:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/hmms_back.sv]
`default_nettype none

module hmms_back import hmms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  input  logic [7:0] glide_steps,
  input  logic       out_ready,
  output logic       out_valid,
  output out_item_t  out_data
);

  back_state_t        state_r, state_nxt;
  logic               pending_r, pending_nxt;
  logic signed [15:0] goal_x_r, goal_x_nxt;
  logic signed [15:0] goal_y_r, goal_y_nxt;
  logic signed [15:0] done_x_r, done_x_nxt;
  logic signed [15:0] done_y_r, done_y_nxt;
  logic        [7:0]  held_buttons_r, held_buttons_nxt;
  logic signed [7:0]  held_wheel_r, held_wheel_nxt;
  logic signed [7:0]  held_pan_r, held_pan_nxt;
  logic        [7:0]  step_count_r, step_count_nxt;
  logic signed [16:0] diff_x_r, diff_x_nxt;
  logic signed [16:0] diff_y_r, diff_y_nxt;
  logic signed [15:0] stx_r, stx_nxt;
  logic signed [15:0] sty_r, sty_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               active;
  logic               goal_set;
  logic               move_run;
  logic               out_free;
  logic               wp_live;
  logic signed [16:0] gap_x;
  logic signed [16:0] gap_y;
  logic        [7:0]  divisor;
  logic               div_start;
  logic               dx_done;
  logic               dy_done;
  logic               div_done;
  logic signed [15:0] qx;
  logic signed [15:0] qy;
  logic signed [15:0] adj_x;
  logic signed [15:0] adj_y;
  logic signed [17:0] rest_x;
  logic signed [17:0] rest_y;
  logic               near_x;
  logic               near_y;
  logic signed [15:0] done_new_x;
  logic signed [15:0] done_new_y;
  logic        [7:0]  step_new;
  logic               finish;
  logic               em_en;
  logic        [7:0]  em_dx;
  logic        [7:0]  em_dy;
  logic        [7:0]  em_wh;
  logic        [7:0]  em_pn;

  function automatic logic [7:0] clamp127(input logic signed [15:0] v);
    logic [7:0] r;
    if (v > 16'sd127) begin
      r = 8'd127;
    end else if (v < -16'sd127) begin
      r = 8'h81;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  assign goal_set = (goal_x_r != 16'sd0) || (goal_y_r != 16'sd0);
  assign wp_live  = (held_wheel_r != 8'sd0) || (held_pan_r != 8'sd0);
  assign active   = pending_r || goal_set || wp_live;
  assign move_run = goal_set && (step_count_r < glide_steps);
  assign out_free = !out_valid_r || out_ready;

  // full-width distance left; its low 16 bits are the wrapped remainder
  assign gap_x   = {goal_x_r[15], goal_x_r} - {done_x_r[15], done_x_r};
  assign gap_y   = {goal_y_r[15], goal_y_r} - {done_y_r[15], done_y_r};
  assign divisor = glide_steps - step_count_r;

  hmms_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ($signed(gap_x[15:0])),
    .divisor  (divisor),
    .done     (dx_done),
    .quotient (qx)
  );

  hmms_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ($signed(gap_y[15:0])),
    .divisor  (divisor),
    .done     (dy_done),
    .quotient (qy)
  );

  assign div_done = dx_done && dy_done;

  // a step never rounds to nothing while distance remains
  always_comb begin
    adj_x = qx;
    adj_y = qy;
    if ((qx == 16'sd0) && (diff_x_r[15:0] != 16'd0)) begin
      adj_x = diff_x_r[15] ? -16'sd1 : 16'sd1;
    end
    if ((qy == 16'sd0) && (diff_y_r[15:0] != 16'd0)) begin
      adj_y = diff_y_r[15] ? -16'sd1 : 16'sd1;
    end
  end

  assign rest_x     = {diff_x_r[16], diff_x_r} - {{2{stx_r[15]}}, stx_r};
  assign rest_y     = {diff_y_r[16], diff_y_r} - {{2{sty_r[15]}}, sty_r};
  assign near_x     = (rest_x >= -18'sd1) && (rest_x <= 18'sd1);
  assign near_y     = (rest_y >= -18'sd1) && (rest_y <= 18'sd1);
  assign done_new_x = done_x_r + stx_r;
  assign done_new_y = done_y_r + sty_r;
  assign step_new   = step_count_r + 8'd1;
  assign finish     = (step_new >= glide_steps) || (near_x && near_y);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free && (q_cmd.op == OP_TICK) && active && move_run) begin
          state_nxt = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (div_done) begin
          state_nxt = BK_APPLY;
        end
      end
      BK_APPLY: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pending_nxt      = pending_r;
    goal_x_nxt       = goal_x_r;
    goal_y_nxt       = goal_y_r;
    done_x_nxt       = done_x_r;
    done_y_nxt       = done_y_r;
    held_buttons_nxt = held_buttons_r;
    held_wheel_nxt   = held_wheel_r;
    held_pan_nxt     = held_pan_r;
    step_count_nxt   = step_count_r;
    diff_x_nxt       = diff_x_r;
    diff_y_nxt       = diff_y_r;
    stx_nxt          = stx_r;
    sty_nxt          = sty_r;
    q_pop            = 1'b0;
    div_start        = 1'b0;
    em_en            = 1'b0;
    em_dx            = 8'd0;
    em_dy            = 8'd0;
    em_wh            = 8'd0;
    em_pn            = 8'd0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_TICK: begin
              if (active) begin
                if (move_run) begin
                  div_start  = 1'b1;
                  diff_x_nxt = gap_x;
                  diff_y_nxt = gap_y;
                end else begin
                  // stalled or no move: zero motion, wheel and pan go out once
                  em_en          = 1'b1;
                  em_wh          = held_wheel_r;
                  em_pn          = held_pan_r;
                  held_wheel_nxt = 8'sd0;
                  held_pan_nxt   = 8'sd0;
                  pending_nxt    = wp_live;
                end
              end
            end
            OP_REPORT: begin
              em_en = 1'b1;
              em_dx = q_cmd.x[7:0];
              em_dy = q_cmd.y[7:0];
            end
            OP_GOAL: begin
              if ((q_cmd.x != goal_x_r) || (q_cmd.y != goal_y_r)) begin
                step_count_nxt = 8'd0;
                done_x_nxt     = 16'sd0;
                done_y_nxt     = 16'sd0;
                goal_x_nxt     = q_cmd.x;
                goal_y_nxt     = q_cmd.y;
                pending_nxt    = 1'b1;
              end
            end
            OP_BUTTONS: begin
              held_buttons_nxt = q_cmd.val;
              pending_nxt      = 1'b1;
            end
            OP_WHEEL: begin
              held_wheel_nxt = $signed(q_cmd.val);
              pending_nxt    = 1'b1;
            end
            OP_PAN: begin
              held_pan_nxt = $signed(q_cmd.val);
              pending_nxt  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      BK_DIVIDE: begin
        if (div_done) begin
          stx_nxt = adj_x;
          sty_nxt = adj_y;
        end
      end
      BK_APPLY: begin
        if (out_free) begin
          em_en          = 1'b1;
          em_dx          = clamp127(stx_r);
          em_dy          = clamp127(sty_r);
          em_wh          = held_wheel_r;
          em_pn          = held_pan_r;
          held_wheel_nxt = 8'sd0;
          held_pan_nxt   = 8'sd0;
          pending_nxt    = wp_live;
          if (finish) begin
            done_x_nxt     = goal_x_r;
            done_y_nxt     = goal_y_r;
            goal_x_nxt     = 16'sd0;
            goal_y_nxt     = 16'sd0;
            step_count_nxt = 8'd0;
          end else begin
            done_x_nxt     = done_new_x;
            done_y_nxt     = done_new_y;
            step_count_nxt = step_new;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (em_en) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.report_buttons = held_buttons_r;
      out_data_nxt.report_dx      = em_dx;
      out_data_nxt.report_dy      = em_dy;
      out_data_nxt.report_wheel   = em_wh;
      out_data_nxt.report_pan     = em_pn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= BK_IDLE;
      pending_r      <= 1'b0;
      goal_x_r       <= 16'sd0;
      goal_y_r       <= 16'sd0;
      done_x_r       <= 16'sd0;
      done_y_r       <= 16'sd0;
      held_buttons_r <= 8'd0;
      held_wheel_r   <= 8'sd0;
      held_pan_r     <= 8'sd0;
      step_count_r   <= 8'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pending_r      <= pending_nxt;
      goal_x_r       <= goal_x_nxt;
      goal_y_r       <= goal_y_nxt;
      done_x_r       <= done_x_nxt;
      done_y_r       <= done_y_nxt;
      held_buttons_r <= held_buttons_nxt;
      held_wheel_r   <= held_wheel_nxt;
      held_pan_r     <= held_pan_nxt;
      step_count_r   <= step_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_x_r   <= diff_x_nxt;
    diff_y_r   <= diff_y_nxt;
    stx_r      <= stx_nxt;
    sty_r      <= sty_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/hid_mouse_motion_smoother.sv]
// path: a direct or raw report passes a queue entry and then the output register;
//   a moving tick leaves the queue, waits in BK_DIVIDE, then BK_APPLY registers it
// throughput: the input queue takes one item a cycle while it has room; the back end
//   retires an item a cycle if output is free; a moving tick waits on two radix-2 dividers
// reset: rst_n synchronous active low; clears queue, motion, buttons and wheel state,
//   loads the step span 24 and direct_limit 63; no clearing pass
`default_nettype none

module hid_mouse_motion_smoother import hmms_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] glide_steps_r;
  logic [6:0] direct_limit_r;
  logic       q_push;
  cmd_t       q_push_cmd;
  logic       q_ready;
  logic       q_pop;
  logic       q_valid;
  cmd_t       q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glide_steps_r  <= GLIDE_STEPS_RESET;
      direct_limit_r <= DIRECT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GLIDE_STEPS:  glide_steps_r  <= cfg_data;
        CFG_DIRECT_LIMIT: direct_limit_r <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // items that classify to nothing are still taken, just not queued
  assign in_ready = q_ready;

  hmms_front u_front (
    .in_valid     (in_valid),
    .in_data      (in_data),
    .direct_limit (direct_limit_r),
    .push         (q_push),
    .cmd          (q_push_cmd)
  );

  hmms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_cmd)
  );

  hmms_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .glide_steps (glide_steps_r),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

`ifndef NO_ASSERTIONS
  a_tick_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.action == ACT_TICK)) |-> q_push)
    else $error("accepted tick was not queued");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid || out_ready))
    else $error("back end popped while the result register was blocked");

  a_full_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input stalled with nothing queued");
`endif

endmodule

`default_nettype wire

[bench/tb_hid_mouse_motion_smoother.sv]
module tb_hid_mouse_motion_smoother;
  import hmms_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 8;
  localparam int EVENTS_PER_PHASE = 219;
  localparam int RUN_LIMIT = 20 * 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  hid_mouse_motion_smoother dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predicted smoother state
  logic [7:0] cfg_steps;
  logic [6:0] cfg_limit;
  bit report_due;
  logic signed [15:0] aim_x, aim_y, moved_x, moved_y;
  logic [7:0] btn_state;
  logic signed [7:0] wheel_latch, pan_latch;
  logic [7:0] steps_taken;

  in_item_t mouse_events[$];
  out_item_t pending_reports[$];

  int err_count = 0;
  int reports_checked = 0;
  int events_sent = 0;
  int gen_count;
  int gap_pct = 20;
  int stall_pct = 20;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;
  logic signed [15:0] last_aim_x = 16'sd300;
  logic signed [15:0] last_aim_y = 16'sd0;

  out_item_t want;
  out_item_t made;
  bit made_one;

  logic [7:0] steps_plan [PHASES] = '{8'd24, 8'd1, 8'd255, 8'd6, 8'd0, 8'd3, 8'd12, 8'd2};
  logic [7:0] limit_plan [PHASES] = '{8'd63, 8'd0, 8'd127, 8'hC8, 8'd10, 8'd127, 8'd1, 8'd40};

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("%s got %02h, predicted %02h", name, got, exp_val));
  endtask

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_report(int v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  function automatic int to_s16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic out_item_t build_report(int dx, int dy, int wh, int pn);
    out_item_t r;
    r.report_buttons = btn_state;
    r.report_dx = dx[7:0];
    r.report_dy = dy[7:0];
    r.report_wheel = wh[7:0];
    r.report_pan = pn[7:0];
    return r;
  endfunction

  function automatic void reset_model();
    cfg_steps = GLIDE_STEPS_RESET;
    cfg_limit = DIRECT_LIMIT_RESET;
    report_due = 1'b0;
    aim_x = '0;
    aim_y = '0;
    moved_x = '0;
    moved_y = '0;
    btn_state = '0;
    wheel_latch = '0;
    pan_latch = '0;
    steps_taken = '0;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    if (idx == CFG_GLIDE_STEPS)
      cfg_steps = val;
    else if (idx == CFG_DIRECT_LIMIT)
      cfg_limit = val[6:0];
  endfunction

  // one tick: step toward the goal, flush the wheel and pan latches
  function automatic out_item_t advance_motion();
    int tx, ty, rem, stx, sty, sx, sy, sw, sp;
    sx = 0;
    sy = 0;
    sw = 0;
    sp = 0;
    report_due = 1'b0;
    if ((aim_x != 0 || aim_y != 0) && steps_taken < cfg_steps) begin
      tx = to_s16(int'(aim_x) - int'(moved_x));
      ty = to_s16(int'(aim_y) - int'(moved_y));
      rem = int'(cfg_steps) - int'(steps_taken);
      stx = tx / rem;
      sty = ty / rem;
      if (stx == 0 && tx > 0) stx = 1;
      if (stx == 0 && tx < 0) stx = -1;
      if (sty == 0 && ty > 0) sty = 1;
      if (sty == 0 && ty < 0) sty = -1;
      sx = clamp_report(stx);
      sy = clamp_report(sty);
      moved_x = moved_x + stx[15:0];
      moved_y = moved_y + sty[15:0];
      steps_taken = steps_taken + 8'd1;
      if (steps_taken >= cfg_steps ||
          (abs_int(int'(aim_x) - int'(moved_x)) <= 1 &&
           abs_int(int'(aim_y) - int'(moved_y)) <= 1)) begin
        moved_x = aim_x;
        moved_y = aim_y;
        steps_taken = '0;
        aim_x = '0;
        aim_y = '0;
      end
    end
    if (wheel_latch != 0 || pan_latch != 0) begin
      sw = int'(wheel_latch);
      sp = int'(pan_latch);
      wheel_latch = '0;
      pan_latch = '0;
      report_due = 1'b1;
    end
    return build_report(sx, sy, sw, sp);
  endfunction

  function automatic void predict_report(input in_item_t ev, output bit produced,
                                         output out_item_t rep);
    int mx, my, rx, ry;
    produced = 1'b0;
    rep = '0;
    mx = int'(ev.move_x);
    my = int'(ev.move_y);
    case (ev.action)
      ACT_TICK: begin
        if (report_due || aim_x != 0 || aim_y != 0 || wheel_latch != 0 || pan_latch != 0) begin
          rep = advance_motion();
          produced = 1'b1;
        end
      end
      ACT_MOVE: begin
        if (mx != 0 || my != 0) begin
          if (abs_int(mx) <= int'(cfg_limit) && abs_int(my) <= int'(cfg_limit)) begin
            rep = build_report(mx, my, 0, 0);
            produced = 1'b1;
          end else if (mx != aim_x || my != aim_y) begin
            steps_taken = '0;
            moved_x = '0;
            moved_y = '0;
            aim_x = ev.move_x;
            aim_y = ev.move_y;
            report_due = 1'b1;
          end
        end
      end
      ACT_BUTTONS: begin
        btn_state = ev.button_mask;
        report_due = 1'b1;
      end
      ACT_WHEEL: begin
        wheel_latch = ev.wheel_amount;
        report_due = 1'b1;
      end
      ACT_PAN: begin
        pan_latch = ev.pan_amount;
        report_due = 1'b1;
      end
      ACT_RAW: begin
        rx = int'($signed(ev.move_x[7:0]));
        ry = int'($signed(ev.move_y[7:0]));
        if (rx != 0 || ry != 0) begin
          rep = build_report(rx, ry, 0, 0);
          produced = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // stimulus helpers
  task automatic add_event(logic [2:0] act, logic signed [15:0] x, logic signed [15:0] y,
                           logic [7:0] val);
    in_item_t ev;
    ev.action = act;
    ev.move_x = x;
    ev.move_y = y;
    ev.button_mask = val;
    ev.wheel_amount = val;
    ev.pan_amount = val;
    mouse_events.push_back(ev);
    if (act <= ACT_RAW) gen_count++;
  endtask

  function automatic logic signed [15:0] near_coord();
    int v;
    v = $urandom_range(int'(cfg_limit));
    if ($urandom_range(1)) v = -v;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] far_coord();
    int v;
    case ($urandom_range(3))
      0: v = int'(cfg_limit) + 1;
      1: v = int'(cfg_limit) + 1 + $urandom_range(400);
      2: v = $urandom_range(32767);
      default: v = 32768;
    endcase
    if ($urandom_range(1)) v = -v;
    return v[15:0];
  endfunction

  task automatic add_ticks(int n, bit mixed);
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      if (mixed && $urandom_range(99) < 15) begin
        act = ACT_BUTTONS + 3'($urandom_range(2));
        add_event(act, 16'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        add_event(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic queue_gesture();
    int k;
    logic signed [15:0] x, y, t;
    logic [2:0] act;
    k = $urandom_range(99);
    if (k < 40) begin
      x = far_coord();
      y = $urandom_range(2) == 0 ? far_coord() : near_coord();
      if ($urandom_range(1)) begin
        t = x;
        x = y;
        y = t;
      end
      last_aim_x = x;
      last_aim_y = y;
      add_event(ACT_MOVE, x, y, 8'($urandom));
      add_ticks($urandom_range(1, 30), 1'b1);
    end else if (k < 50) begin
      // repeat of the current goal must not restart it
      add_event(ACT_MOVE, last_aim_x, last_aim_y, 8'($urandom));
      add_ticks($urandom_range(1, 5), 1'b0);
    end else if (k < 65) begin
      for (int i = $urandom_range(1, 4); i > 0; i--)
        add_event(ACT_MOVE, near_coord(), near_coord(), 8'($urandom));
    end else if (k < 75) begin
      x = 16'($urandom);
      y = 16'($urandom);
      if ($urandom_range(7) == 0) begin
        x[7:0] = '0;
        y[7:0] = '0;
      end
      add_event(ACT_RAW, x, y, 8'($urandom));
    end else if (k < 88) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) begin
        act = ACT_BUTTONS + 3'($urandom_range(2));
        add_event(act, 16'($urandom), 16'($urandom),
                  $urandom_range(3) == 0 ? 8'd0 : 8'($urandom));
      end
      add_ticks($urandom_range(1, 3), 1'b0);
    end else if (k < 95) begin
      add_event(ACT_MOVE, 16'sd0, 16'sd0, 8'($urandom));
      add_event(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      act = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      if ($urandom_range(1)) act = 3'($urandom_range(7));
      add_event(act, 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic queue_directed();
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_MOVE, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_MOVE, 16'sd63, -16'sd63, 8'd0);
    add_event(ACT_MOVE, 16'sh8000, 16'sh7FFF, 8'd0);
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_MOVE, 16'sh8000, 16'sh7FFF, 8'd0);
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_BUTTONS, 16'sd0, 16'sd0, 8'hFF);
    add_event(ACT_WHEEL, 16'sd0, 16'sd0, 8'h80);
    add_event(ACT_PAN, 16'sd0, 16'sd0, 8'h7F);
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
    // a zero wheel is latched as well and still asks for a report
    add_event(ACT_WHEEL, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_RAW, 16'sh1234, 16'shFF80, 8'd0);
    add_event(ACT_RAW, 16'sh0100, 16'shFF00, 8'd0);
    add_event(ACT_MOVE, 16'sd64, 16'sd0, 8'd0);
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_BUTTONS, 16'sd0, 16'sd0, 8'h00);
    add_event(ACT_SPARE_LO, 16'sd5, 16'sd5, 8'h55);
    add_event(ACT_SPARE_HI, 16'sd5, 16'sd5, 8'hAA);
    add_event(ACT_MOVE, -16'sd64, -16'sd1, 8'd0);
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
    add_event(ACT_PAN, 16'sd0, 16'sd0, 8'hFF);
    add_event(ACT_TICK, 16'sd0, 16'sd0, 8'd0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (mouse_events.size() != 0 || in_valid || pending_reports.size() != 0)
      @(negedge clk);
    // items without a report may still be in the back end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (mouse_events.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_data <= mouse_events.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // report receiver, with one long hold-off during phase 2
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: track transfers, predict and compare
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          report_error("report transfer with nothing predicted");
        end else begin
          want = pending_reports.pop_front();
          check_field("buttons", out_data.report_buttons, want.report_buttons);
          check_field("dx", out_data.report_dx, want.report_dx);
          check_field("dy", out_data.report_dy, want.report_dy);
          check_field("wheel", out_data.report_wheel, want.report_wheel);
          check_field("pan", out_data.report_pan, want.report_pan);
          reports_checked++;
        end
      end
      if (cfg_valid && cfg_ready) apply_config(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        predict_report(in_data, made_one, made);
        if (made_one) pending_reports.push_back(made);
        events_sent++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_model();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        queue_directed();
      end else begin
        write_register(CFG_GLIDE_STEPS, steps_plan[ph]);
        write_register(CFG_DIRECT_LIMIT, limit_plan[ph]);
        if (ph == 1) write_register(CFG_SPARE, 8'h5A);
      end
      // phases 3 and 4 run with both sides always ready
      gap_pct = (ph == 3 || ph == 4) ? 0 : 20;
      stall_pct = (ph == 3 || ph == 4) ? 0 : 20;
      gen_count = 0;
      while (gen_count < EVENTS_PER_PHASE) queue_gesture();
      if (ph == 2) hold_seq++;
      drain();
    end

    $display("covered %0d events across %0d register settings, %0d reports compared",
             events_sent, PHASES, reports_checked);
    $display("settings included one-step and stalled smoothing and limits 0 to 127");
    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d reports still predicted", pending_reports.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
